// File: rtl/lpl_pkg.sv
package lpl_pkg;

  localparam int LookaheadMaxDef = 1024;
  localparam int SampleBitsDef   = 24;

  localparam int GainW    = 24;
  localparam int CoefW    = 24;
  localparam int LevelW   = 23;
  localparam int LenW     = 11;
  localparam int ChanW    = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  localparam logic [GainW-1:0]  Unity           = 24'd8388608;
  localparam logic [LevelW-1:0] ClampLevelRst   = 23'd8292287;
  localparam logic [LevelW-1:0] DetectLevelRst  = 23'd8178730;
  localparam logic [LevelW-1:0] MinGainRst      = 23'd33;
  localparam logic [CoefW-1:0]  ReleaseCoeffRst = 24'd16773000;
  localparam logic [LenW-1:0]   LookaheadRst    = 11'd64;
  localparam logic [ChanW-1:0]  ChannelsRst     = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CLAMP     = 3'd0,
    REG_DETECT    = 3'd1,
    REG_MIN_GAIN  = 3'd2,
    REG_RELEASE   = 3'd3,
    REG_LOOKAHEAD = 3'd4,
    REG_CHANNELS  = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_FETCH,
    ST_DIV,
    ST_BOUND,
    ST_ENV,
    ST_OMUL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clear;
    logic en;
    logic first;
  } cell_ctrl_t;

endpackage

// File: rtl/lpl_ring.sv
module lpl_ring #(
  parameter int Depth = 1025,
  parameter int AddrW = 11,
  parameter int DataW = 24
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lpl_peak_cell.sv
module lpl_peak_cell #(
  parameter int SampleBits = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lpl_pkg::cell_ctrl_t          ctrl_i,
  input  logic signed [SampleBits-1:0] sample_i,
  output logic [SampleBits+1:0]        peak_o
);
  import lpl_pkg::*;

  localparam int EW = SampleBits + 3;
  localparam int PW = SampleBits + 2;

  logic signed [SampleBits-1:0] prev_q;
  logic [PW-1:0] peak_q, peak_d;
  logic signed [EW-1:0] ae, pe, s2, s3a, sa3;
  logic [EW-1:0] abs_a, abs_s2, abs_s3a, abs_sa3;
  logic [PW-1:0] m4, m2, m3a, ma3;

  function automatic logic [EW-1:0] abs_v(input logic signed [EW-1:0] v);
    abs_v = v[EW-1] ? EW'(-v) : EW'(v);
  endfunction

  always_comb begin
    ae  = EW'(sample_i);
    pe  = EW'(prev_q);
    s2  = ae + pe;
    s3a = (ae <<< 1) + ae + pe;
    sa3 = ae + (pe <<< 1) + pe;
    abs_a   = abs_v(ae);
    abs_s2  = abs_v(s2);
    abs_s3a = abs_v(s3a);
    abs_sa3 = abs_v(sa3);
    // Every candidate is in quarter-LSB units and stays within 2^(SampleBits+1).
    m4  = {abs_a[SampleBits-1:0], 2'b00};
    m2  = {abs_s2[SampleBits:0], 1'b0};
    m3a = abs_s3a[PW-1:0];
    ma3 = abs_sa3[PW-1:0];
    peak_d = peak_q;
    if (m4 > peak_d) peak_d = m4;
    if (!ctrl_i.first) begin
      if (m2 > peak_d)  peak_d = m2;
      if (m3a > peak_d) peak_d = m3a;
      if (ma3 > peak_d) peak_d = ma3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
      prev_q <= '0;
    end else if (ctrl_i.clear) begin
      peak_q <= '0;
    end else if (ctrl_i.en) begin
      peak_q <= peak_d;
      prev_q <= sample_i;
    end
  end

  assign peak_o = peak_q;

endmodule

// File: rtl/lpl_div.sv
module lpl_div #(
  parameter int NumW = 48,
  parameter int DenW = 26,
  parameter int QuoW = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [QuoW-1:0] quo_o
);
  import lpl_pkg::*;

  localparam int CntW = $clog2(QuoW + 1);

  logic [DenW:0]   rem_q;
  logic [DenW-1:0] den_q;
  logic [QuoW-1:0] low_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW:0]   trial;
  logic            fits;

  // The caller guarantees a quotient below 2^QuoW, so the top part of the
  // numerator is already smaller than the divisor.
  always_comb begin
    trial = {rem_q[DenW-1:0], low_q[QuoW-1]};
    fits  = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rem_q <= '0;
      den_q <= '0;
      low_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(QuoW);
      rem_q <= (DenW+1)'(num_i[NumW-1:QuoW]);
      den_q <= den_i;
      low_q <= num_i[QuoW-1:0];
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
      rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
      low_q <= {low_q[QuoW-2:0], fits};
    end
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = low_q;

endmodule

// File: rtl/lookahead_peak_limiter_top.sv
// Look-ahead peak limiter for an oversampled stereo or mono stream.
// Input frames arrive as beats on the in channel (in_valid_i / in_stall_o);
// each accepted beat yields exactly one result beat on the out channel
// (out_valid_o / out_stall_i) carrying the frame from L frames ago scaled by
// the gain envelope, the envelope itself and the safety clamp flags.
// Each frame is stored into the delay rings (the right one only in stereo),
// then a pair of peak cells walks the newest L ring entries, one entry per
// cycle through the ring read port. When the peak is above the detect level,
// the result beat follows the ring scan, a read of the delayed frame, the
// divider start, the serial gain divider, the gain bound, the release update,
// the output multiply and the output load. Below the detect level the divider
// is skipped. The next frame can be taken in the cycle after the result is
// loaded. Only one frame is in work at a time; the result sits in an output
// register, so a stalled receiver only holds the block once the next result
// is ready to be written. After reset the rings are swept to zero, one entry
// a cycle, over all LOOKAHEAD_MAX + 1 entries; in_stall_o stays high during
// that sweep.
// Configuration writes (cfg_valid_i, index, data) are always taken; they
// should only be issued while the block is idle.
module lookahead_peak_limiter_top #(
  parameter int LOOKAHEAD_MAX = lpl_pkg::LookaheadMaxDef,
  parameter int SAMPLE_BITS   = lpl_pkg::SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] right_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o,
  output logic [lpl_pkg::GainW-1:0]     gain_now_o,
  output logic [1:0]                    clamp_hits_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lpl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lpl_pkg::CfgDataW-1:0]  cfg_data_i
);
  import lpl_pkg::*;

  localparam int Depth = LOOKAHEAD_MAX + 1;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(Depth + 1);
  localparam int SB    = SAMPLE_BITS;
  localparam int PW    = SB + 2;
  localparam int NW    = SB + 24;
  localparam int MW    = SB + GainW;
  localparam int YW    = SB + 2;
  localparam int CmpW  = SB + 26;

  // Configuration registers.
  logic [LevelW-1:0] clamp_q, detect_q, min_gain_q;
  logic [CoefW-1:0]  release_q;
  logic [LenW-1:0]   look_q;
  logic [ChanW-1:0]  chan_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_q    <= ClampLevelRst;
      detect_q   <= DetectLevelRst;
      min_gain_q <= MinGainRst;
      release_q  <= ReleaseCoeffRst;
      look_q     <= LookaheadRst;
      chan_q     <= ChannelsRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CLAMP:     clamp_q    <= cfg_data_i[LevelW-1:0];
        REG_DETECT:    detect_q   <= cfg_data_i[LevelW-1:0];
        REG_MIN_GAIN:  min_gain_q <= cfg_data_i[LevelW-1:0];
        REG_RELEASE:   release_q  <= cfg_data_i[CoefW-1:0];
        REG_LOOKAHEAD: look_q     <= cfg_data_i[LenW-1:0];
        REG_CHANNELS:  chan_q     <= cfg_data_i[ChanW-1:0];
        default: ;
      endcase
    end
  end

  // Effective window length, ring length and write position.
  logic [CW-1:0] len_c, ring_len_c, pos_ext;
  logic [AW-1:0] pos_c, npos_c;
  logic          stereo_c;

  always_comb begin
    if (look_q == '0) begin
      len_c = CW'(1);
    end else if (32'(look_q) > 32'(LOOKAHEAD_MAX)) begin
      len_c = CW'(LOOKAHEAD_MAX);
    end else begin
      len_c = CW'(look_q);
    end
    ring_len_c = len_c + 1'b1;
    stereo_c   = chan_q >= 2'd2;
  end

  state_e state_q, state_d;
  logic [AW-1:0] rpos_q, npos_q, rd_addr_q, clr_q;
  logic [CW-1:0] cnt_q, len_q, ring_len_q;
  logic          stereo_q;

  always_comb begin
    pos_c   = (CW'(rpos_q) >= ring_len_c) ? '0 : rpos_q;
    pos_ext = CW'(pos_c) + 1'b1;
    npos_c  = (pos_ext == ring_len_c) ? '0 : AW'(pos_ext);
  end

  // Ring memories and peak cells.
  logic          accept, ring_we_l, ring_we_r;
  logic [AW-1:0] waddr, raddr;
  logic [SB-1:0] wdata_l, wdata_r, rdata_l, rdata_r;
  cell_ctrl_t    cell_ctrl;
  logic          sv_q, first_q;
  logic [PW-1:0] peak_l, peak_r, peak_c;

  lpl_ring #(.Depth(Depth), .AddrW(AW), .DataW(SB)) u_ring_l (
    .clk_i(clk_i), .we_i(ring_we_l), .waddr_i(waddr), .wdata_i(wdata_l),
    .raddr_i(raddr), .rdata_o(rdata_l)
  );

  lpl_ring #(.Depth(Depth), .AddrW(AW), .DataW(SB)) u_ring_r (
    .clk_i(clk_i), .we_i(ring_we_r), .waddr_i(waddr), .wdata_i(wdata_r),
    .raddr_i(raddr), .rdata_o(rdata_r)
  );

  lpl_peak_cell #(.SampleBits(SB)) u_cell_l (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(cell_ctrl),
    .sample_i(signed'(rdata_l)), .peak_o(peak_l)
  );

  lpl_peak_cell #(.SampleBits(SB)) u_cell_r (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(cell_ctrl),
    .sample_i(signed'(rdata_r)), .peak_o(peak_r)
  );

  assign peak_c = (stereo_q && (peak_r > peak_l)) ? peak_r : peak_l;

  // Gain target: detect level over the peak; the peak is in quarter-LSB units, the level in sample LSBs.
  logic [NW-1:0]   div_num;
  logic            over_c, div_start, div_busy;
  logic [GainW-1:0] div_quo;

  always_comb begin
    div_num = {detect_q, (SB + 1)'(0)};
    over_c  = CmpW'({peak_c, 23'b0}) > CmpW'(div_num);
  end

  lpl_div #(.NumW(NW), .DenW(PW), .QuoW(GainW)) u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .num_i(div_num),
    .den_i(peak_c), .busy_o(div_busy), .quo_o(div_quo)
  );

  // Next state.
  logic out_free, out_load;
  assign out_free = !out_valid_o || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (32'(clr_q) == 32'(Depth - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:  if (cnt_q == len_q - 1'b1) state_d = ST_TAIL;
      ST_TAIL:  state_d = ST_FETCH;
      ST_FETCH: state_d = over_c ? ST_DIV : ST_BOUND;
      ST_DIV:   if (!div_busy) state_d = ST_BOUND;
      ST_BOUND: state_d = ST_ENV;
      ST_ENV:   state_d = ST_OMUL;
      ST_OMUL:  state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall_o = 1'b1;
    accept     = 1'b0;
    ring_we_l  = 1'b0;
    ring_we_r  = 1'b0;
    waddr      = pos_c;
    wdata_l    = left_sample_i;
    wdata_r    = right_sample_i;
    raddr      = rd_addr_q;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ring_we_l = 1'b1;
        ring_we_r = 1'b1;
        waddr     = clr_q;
        wdata_l   = '0;
        wdata_r   = '0;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
        ring_we_l  = in_valid_i;
        ring_we_r  = in_valid_i && stereo_c;
      end
      ST_TAIL:  raddr = npos_q;
      ST_FETCH: div_start = over_c;
      ST_OUT:   out_load = out_free;
      default: ;
    endcase
    cell_ctrl.clear = accept;
    cell_ctrl.en    = sv_q;
    cell_ctrl.first = first_q;
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      rpos_q     <= '0;
      npos_q     <= '0;
      rd_addr_q  <= '0;
      cnt_q      <= '0;
      len_q      <= '0;
      ring_len_q <= '0;
      stereo_q   <= 1'b0;
      sv_q       <= 1'b0;
      first_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sv_q    <= state_q == ST_SCAN;
      first_q <= (state_q == ST_SCAN) && (cnt_q == '0);
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (accept) begin
        npos_q     <= npos_c;
        rpos_q     <= npos_c;
        rd_addr_q  <= pos_c;
        cnt_q      <= '0;
        len_q      <= len_c;
        ring_len_q <= ring_len_c;
        stereo_q   <= stereo_c;
      end else if (state_q == ST_SCAN) begin
        cnt_q     <= cnt_q + 1'b1;
        rd_addr_q <= (rd_addr_q == '0) ? AW'(ring_len_q - 1'b1) : rd_addr_q - 1'b1;
      end
    end
  end

  // Gain datapath.
  logic [GainW-1:0]   env_q, target_q, bound_c, ml_env;
  logic [2*GainW-1:0] prod_q;
  logic [SB-1:0]      xl_q, xr_q, abs_l, abs_r;
  logic [MW-1:0]      ml_q, mr_q;

  always_comb begin
    bound_c = (target_q > Unity) ? Unity : target_q;
    if (bound_c < GainW'(min_gain_q)) bound_c = GainW'(min_gain_q);
    ml_env  = target_q - prod_q[2*GainW-1:GainW];
    abs_l   = xl_q[SB-1] ? SB'(-xl_q) : xl_q;
    abs_r   = xr_q[SB-1] ? SB'(-xr_q) : xr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q <= Unity;
    end else if ((state_q == ST_BOUND) && (bound_c < env_q)) begin
      env_q <= bound_c;
    end else if (state_q == ST_ENV && (target_q >= env_q)) begin
      env_q <= ml_env;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_FETCH: begin
        xl_q     <= rdata_l;
        xr_q     <= stereo_q ? rdata_r : '0;
        target_q <= Unity;
      end
      ST_DIV:   if (!div_busy) target_q <= div_quo;
      ST_BOUND: begin
        target_q <= bound_c;
        // On an instant drop the envelope already equals the target, so the
        // release step must leave it there.
        prod_q   <= (bound_c < env_q) ? '0
                  : (2*GainW)'(bound_c - env_q) * (2*GainW)'(release_q);
      end
      ST_OMUL: begin
        ml_q <= MW'(abs_l) * MW'(env_q);
        mr_q <= MW'(abs_r) * MW'(env_q);
      end
      default: ;
    endcase
  end

  // Output rounding and safety clamp.
  function automatic logic [SB:0] limit(input logic [MW-1:0] prod, input logic neg,
                                        input logic [LevelW-1:0] lvl);
    logic [MW:0]     rnd;
    logic [YW-1:0]   ym;
    logic [CmpW-1:0] lhs, rhs;
    logic [YW-1:0]   y;
    rnd = (MW+1)'(prod) + (MW+1)'(1 << 22);
    ym  = YW'(rnd >> 23);
    lhs = CmpW'(ym) << 23;
    rhs = CmpW'(lvl) << (SB - 1);
    limit[SB] = lhs > rhs;
    if (limit[SB]) ym = YW'(rhs >> 23);
    y = neg ? YW'(-ym) : ym;
    limit[SB-1:0] = y[SB-1:0];
  endfunction

  logic [SB:0] lim_l, lim_r;
  assign lim_l = limit(ml_q, xl_q[SB-1], clamp_q);
  assign lim_r = limit(mr_q, xr_q[SB-1], clamp_q);

  logic out_valid_q;
  logic [SB-1:0] left_q, right_q;
  logic [GainW-1:0] gain_q;
  logic [1:0] hits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      left_q  <= lim_l[SB-1:0];
      right_q <= stereo_q ? lim_r[SB-1:0] : '0;
      gain_q  <= env_q;
      hits_q  <= {stereo_q && lim_r[SB], lim_l[SB]};
    end
  end

  assign out_valid_o  = out_valid_q;
  assign left_out_o   = signed'(left_q);
  assign right_out_o  = signed'(right_q);
  assign gain_now_o   = gain_q;
  assign clamp_hits_o = hits_q;

endmodule

// File: rtl/lpl_chk.sv
module lpl_chk #(
  parameter int SAMPLE_BITS = lpl_pkg::SampleBitsDef
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [SAMPLE_BITS-1:0] left_out_o,
  input logic [lpl_pkg::GainW-1:0] gain_now_o
);
  import lpl_pkg::*;

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result beat shown during reset");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second frame taken before the first finished");

  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> gain_now_o <= Unity)
    else $error("gain above unity");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(left_out_o)
      && $stable(gain_now_o))
    else $error("stalled result beat changed");

endmodule

bind lookahead_peak_limiter_top lpl_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_lpl_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
  .left_out_o(left_out_o), .gain_now_o(gain_now_o)
);

// File: tb/lpl_frame_checker.sv
`timescale 1ns / 100ps

// Watches the frame, result and register channels of the limiter, keeps its
// own copy of the delay rings and the gain envelope, and compares every
// result beat against the oldest predicted frame.
module lpl_frame_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_o,
  input  logic signed [23:0]   left_sample_i,
  input  logic signed [23:0]   right_sample_i,
  input  logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  logic signed [23:0]   left_out_o,
  input  logic signed [23:0]   right_out_o,
  input  logic [23:0]          gain_now_o,
  input  logic [1:0]           clamp_hits_o,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [23:0]          cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   results_o
);
  import lpl_pkg::*;

  localparam int RingDepth = LookaheadMaxDef + 1;
  localparam longint unsigned OneQ23 = 64'd8388608;

  typedef struct {
    logic [23:0] left;
    logic [23:0] right;
    logic [23:0] gain;
    logic [1:0]  hits;
  } frame_t;

  frame_t limited_frames[$];

  logic [LevelW-1:0] clamp_lvl;
  logic [LevelW-1:0] detect_lvl;
  logic [LevelW-1:0] floor_gain;
  logic [CoefW-1:0]  release_k;
  logic [LenW-1:0]   look_len;
  logic [ChanW-1:0]  chans;

  int               left_ring [RingDepth];
  int               right_ring[RingDepth];
  int unsigned      wr_pos;
  longint unsigned  envelope;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    results_o    = 0;
  end

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Peak in quarter-LSB units over the newest len entries, with midpoint and
  // quarter-point interpolation between neighbours.
  function automatic longint unsigned window_peak(bit right_ch, int unsigned newest,
                                                  int unsigned len, int unsigned rlen);
    longint unsigned best;
    longint unsigned c;
    longint          a;
    longint          prev;
    int unsigned     idx;
    best = 0;
    prev = 0;
    for (int unsigned k = 0; k < len; k++) begin
      idx = (newest + rlen - k) % rlen;
      a   = right_ch ? right_ring[idx] : left_ring[idx];
      c   = 4 * magnitude(a);
      if (c > best) best = c;
      if (k > 0) begin
        c = 2 * magnitude(a + prev);
        if (c > best) best = c;
        c = magnitude(3 * a + prev);
        if (c > best) best = c;
        c = magnitude(a + 3 * prev);
        if (c > best) best = c;
      end
      prev = a;
    end
    return best;
  endfunction

  function automatic logic [23:0] gain_sample(int x, longint unsigned env, output logic hit);
    longint unsigned m;
    longint unsigned ym;
    longint unsigned ceil_q;
    m      = magnitude(x);
    ym     = (m * env + (OneQ23 >> 1)) >> 23;
    ceil_q = longint'(clamp_lvl) * OneQ23;
    hit    = 1'b0;
    if (ym * OneQ23 > ceil_q) begin
      ym  = ceil_q >> 23;
      hit = 1'b1;
    end
    return (x < 0) ? 24'(-longint'(ym)) : 24'(ym);
  endfunction

  task automatic predict_frame(input logic signed [23:0] l, input logic signed [23:0] r);
    int unsigned     len;
    int unsigned     rlen;
    int unsigned     p;
    int unsigned     np;
    bit              stereo;
    longint unsigned pk;
    longint unsigned pk_r;
    longint unsigned scaled_ceil;
    longint unsigned tgt;
    longint unsigned env;
    logic            hl;
    logic            hr;
    frame_t          f;
    len = look_len;
    if (len < 1) len = 1;
    if (len > LookaheadMaxDef) len = LookaheadMaxDef;
    rlen   = len + 1;
    stereo = (chans >= 2);
    p = wr_pos;
    if (p >= rlen) p = 0;
    left_ring[p] = l;
    if (stereo) right_ring[p] = r;
    np = p + 1;
    if (np == rlen) np = 0;
    wr_pos = np;

    pk = window_peak(1'b0, p, len, rlen);
    if (stereo) begin
      pk_r = window_peak(1'b1, p, len, rlen);
      if (pk_r > pk) pk = pk_r;
    end

    scaled_ceil = longint'(detect_lvl) * OneQ23 * 4;
    tgt = OneQ23;
    if (pk * OneQ23 > scaled_ceil) tgt = scaled_ceil / pk;
    if (tgt > OneQ23) tgt = OneQ23;
    if (tgt < floor_gain) tgt = floor_gain;

    env = envelope;
    if (tgt < env) env = tgt;
    else env = tgt - (((tgt - env) * release_k) >> 24);
    envelope = env;

    hr      = 1'b0;
    f.left  = gain_sample(left_ring[np], env, hl);
    f.right = '0;
    if (stereo) f.right = gain_sample(right_ring[np], env, hr);
    f.gain  = env[23:0];
    f.hits  = {hr, hl};
    limited_frames.push_back(f);
  endtask

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("%0t ns: result %0d %s mismatch: got %0d, expected %0d",
             $time, results_o, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_t f;
    if (!rst_ni) begin
      clamp_lvl  = ClampLevelRst;
      detect_lvl = DetectLevelRst;
      floor_gain = MinGainRst;
      release_k  = ReleaseCoeffRst;
      look_len   = LookaheadRst;
      chans      = ChannelsRst;
      for (int i = 0; i < RingDepth; i++) begin
        left_ring[i]  = 0;
        right_ring[i] = 0;
      end
      wr_pos   = 0;
      envelope = OneQ23;
      limited_frames.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_CLAMP:     clamp_lvl  = cfg_data_i[LevelW-1:0];
          REG_DETECT:    detect_lvl = cfg_data_i[LevelW-1:0];
          REG_MIN_GAIN:  floor_gain = cfg_data_i[LevelW-1:0];
          REG_RELEASE:   release_k  = cfg_data_i[CoefW-1:0];
          REG_LOOKAHEAD: look_len   = cfg_data_i[LenW-1:0];
          REG_CHANNELS:  chans      = cfg_data_i[ChanW-1:0];
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        if (limited_frames.size() == 0) begin
          report_mismatch("unexpected beat, left_out", left_out_o, '0);
        end else begin
          f = limited_frames.pop_front();
          if (left_out_o !== f.left) report_mismatch("left_out", left_out_o, f.left);
          if (right_out_o !== f.right) report_mismatch("right_out", right_out_o, f.right);
          if (gain_now_o !== f.gain) report_mismatch("gain_now", gain_now_o, f.gain);
          if (clamp_hits_o !== f.hits)
            report_mismatch("clamp_hits", 24'(clamp_hits_o), 24'(f.hits));
        end
        results_o++;
      end
      if (in_valid_i && !in_stall_o) predict_frame(left_sample_i, right_sample_i);
      pending_o <= limited_frames.size();
    end
  end

endmodule

// File: tb/lookahead_peak_limiter_top_tb.sv
`timescale 1ns / 100ps

module lookahead_peak_limiter_top_tb;
  import lpl_pkg::*;

  // A generous bound: the slowest legal run stays well below a tenth of it.
  localparam int CycleLimit = 1000000;
  localparam logic signed [23:0] PosFull = 24'sh7FFFFF;
  localparam logic signed [23:0] NegFull = 24'sh800000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [23:0] left_sample_i = '0;
  logic signed [23:0] right_sample_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [23:0] left_out_o;
  logic signed [23:0] right_out_o;
  logic [GainW-1:0]   gain_now_o;
  logic [1:0]         clamp_hits_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  int fail_count;
  int pending;
  int results;
  int cycles = 0;
  int frames_sent = 0;
  int settings_used = 0;

  // Shared with the receiver process: a long hold-off request and a flag that
  // turns off all random idling on both sides.
  bit hold_req = 1'b0;
  bit no_idle = 1'b0;

  lookahead_peak_limiter_top i_dut (.*);

  lpl_frame_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .left_sample_i, .right_sample_i,
    .out_valid_o, .out_stall_i, .left_out_o, .right_out_o, .gain_now_o,
    .clamp_hits_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side. Normally stalls about a third of the time; on request it
  // holds off for a long stretch, counted here, so the block backs up.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= !no_idle && ($urandom_range(99) < 32);
      end
    end
  end

  // A mix of full-scale, small, zero and random values so the limiter both rests and works hard.
  function automatic logic signed [23:0] pick_sample();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? PosFull : NegFull;
      1: return 24'($signed($urandom_range(8191)) - 4096);
      2: return '0;
      default: return 24'($urandom);
    endcase
  endfunction

  // Offers one frame and waits for its beat. The valid is lowered after the
  // beat only when a gap follows or the caller wants the line quiet.
  task automatic send_frame(input logic signed [23:0] l, input logic signed [23:0] r,
                            input bit last);
    in_valid_i     <= 1'b1;
    left_sample_i  <= l;
    right_sample_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    frames_sent++;
    if (last || (!no_idle && $urandom_range(99) < 32)) begin
      in_valid_i <= 1'b0;
      if (!last) repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes all six registers back to back; the block is idle at this point.
  task automatic apply_settings(input int unsigned clamp, input int unsigned detect,
                                input int unsigned floor_g, input int unsigned rel,
                                input int unsigned look, input int unsigned ch);
    int unsigned vals[6];
    vals = '{clamp, detect, floor_g, rel, look, ch};
    for (int i = 0; i < 6; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_reg_e'(i);
      cfg_data_i  <= vals[i][23:0];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic random_frames(input int count, input bit pause_midway);
    for (int i = 0; i < count; i++) begin
      send_frame(pick_sample(), pick_sample(),
                 (i == count - 1) || (pause_midway && i == count / 2));
      if (pause_midway && i == count / 2) wait_drained();
    end
  endtask

  initial begin
    logic signed [23:0] dir_l[16];
    logic signed [23:0] dir_r[16];
    int unsigned        look;
    dir_l = '{PosFull, NegFull, 24'sd0, 24'sd1, -24'sd1, PosFull, NegFull, PosFull,
              NegFull, 24'sd0, 24'sd0, 24'sd4096, -24'sd4096, 24'sh555555, 24'shAAAAAA, 24'sd0};
    dir_r = '{NegFull, PosFull, 24'sd0, -24'sd1, 24'sd1, PosFull, NegFull, NegFull,
              PosFull, PosFull, 24'sd0, -24'sd4096, 24'sd4096, 24'shAAAAAA, 24'sh555555, 24'sd0};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: extremes, alternating full-scale neighbours to exercise
    // the interpolated peaks, and silence to let the gain recover.
    for (int i = 0; i < 16; i++) send_frame(dir_l[i], dir_r[i], i == 15);
    wait_drained();

    // Zero clamp and detect levels, look-ahead of zero, channel count zero
    // (mono), instant release.
    apply_settings(0, 0, 33, 0, 0, 0);
    for (int i = 0; i < 6; i++) send_frame(i[0] ? PosFull : NegFull, PosFull, i == 5);
    wait_drained();

    // Register maxima: look-ahead beyond the ring saturates, channel count
    // three acts as stereo, slowest release.
    apply_settings(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 11'h7FF, 3);
    random_frames(12, 1'b0);
    wait_drained();

    // Random settings. The phase after the long look-ahead one shrinks the
    // look-ahead while the ring position is deep, so the write position restarts.
    for (int ph = 0; ph < 10; ph++) begin
      look = (ph == 7) ? $urandom_range(100, 300) : $urandom_range(1, 16);
      apply_settings($urandom_range(2105199, 8292287), $urandom_range(2076300, 8178730),
                     $urandom_range(3) == 0 ? 7476355 : $urandom_range(33, 4000000),
                     $urandom_range(1) ? $urandom_range(16700000, 16777215)
                                       : $urandom_range(0, 16777215),
                     look, $urandom_range(1, 2));
      no_idle = (ph == 4);
      if (ph == 2) hold_req = 1'b1;
      random_frames(42, ph == 6);
      wait_drained();
    end

    no_idle = 1'b0;
    repeat (50) @(posedge clk_i);
    $display("Sent %0d frames under %0d register settings; checked %0d results.",
             frames_sent, settings_used, results);
    $display("Covered mono and stereo, zero and saturated look-ahead, zero levels.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
